### src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check on every rising aclk edge outside reset
`define ASSERT_CLKD(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// check on every rising aclk edge, reset included
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLKD(label, prop)
`define ASSERT_ALWAYS(label, prop)

`endif

`endif

### src/drs_pkg.sv
`default_nettype none

package drs_pkg;

    // default capacity and reset value of the top cylinder
    localparam int unsigned MAX_REQUESTS_DEF = 32;
    localparam logic [15:0] MAX_CYL_RESET    = 16'd199;

    // scheduling modes
    localparam logic [1:0] MODE_FCFS  = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_CSCAN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_HEAD    = 2'd1;
    localparam logic [1:0] REG_MAX_CYL = 2'd2;

    // input beat
    typedef struct packed {
        logic [15:0] request_track;
        logic        last_request;
    } req_t;

    // result beat
    typedef struct packed {
        logic [15:0] served_track;
        logic [15:0] move_distance;
        logic [20:0] total_movement;
        logic [5:0]  request_count;
        logic        last_served;
    } res_t;

endpackage

`default_nettype wire

### src/disk_request_scheduler.sv
// disk request scheduler
//
// s_ channel: one request beat per cycle while loading; last_request closes
// the batch. Requests past capacity are dropped, but their last marker still
// closes the batch. cfg_we/cfg_index/cfg_wdata write mode, head_start and
// max_cylinder; write them only while the block is idle.
// m_ channel: the service order, one beat per result, last_served on the
// final one. FCFS gives n results, SCAN n+1, C-SCAN n+2.
// After the last beat, SCAN and C-SCAN first run an insertion sort over the
// request memory, which has one write and one registered read port, then scan
// for the first request at or above the head. Each stored result is then read
// from the memory and emitted; top and zero turnaround results need no read.
// s_ready is low from the last beat until the final result is loaded into
// the output register. A stalled receiver holds the output register and the
// sequencer waits; a new batch may load while the final result waits.
// Reset: synchronous, active low; empties the batch, drops any pending result
// and returns the registers to mode FCFS, head 0, top cylinder 199. The
// request memory is not cleared: only written entries are ever read.
`default_nettype none

`include "assert_macros.svh"

module disk_request_scheduler #(
    parameter int unsigned MAX_REQUESTS = drs_pkg::MAX_REQUESTS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire drs_pkg::req_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output drs_pkg::res_t     m_data
);

    import drs_pkg::*;

    localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    typedef enum logic [11:0] {
        S_LOAD      = 12'b0000_0000_0001,
        S_START     = 12'b0000_0000_0010,
        S_SORT_RD   = 12'b0000_0000_0100,
        S_SORT_X    = 12'b0000_0000_1000,
        S_SORT_CMP  = 12'b0000_0001_0000,
        S_SORT_PUT  = 12'b0000_0010_0000,
        S_FIND_RD   = 12'b0000_0100_0000,
        S_FIND_CMP  = 12'b0000_1000_0000,
        S_EMIT_RD   = 12'b0001_0000_0000,
        S_EMIT_WR   = 12'b0010_0000_0000,
        S_EMIT_TOP  = 12'b0100_0000_0000,
        S_EMIT_ZERO = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        SEG_UP,
        SEG_DN,
        SEG_CU
    } seg_t;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [15:0] head_start_reg;
    logic [15:0] max_cyl_reg;

    // sequencer state
    state_t          state_reg, state_next;
    seg_t            seg_reg, seg_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   first_reg, first_next;
    logic [15:0]     x_reg, x_next;
    logic [15:0]     pos_reg, pos_next;
    logic [20:0]     tot_reg, tot_next;

    // output register
    logic            m_valid_reg;
    res_t            m_data_reg;

    // request memory
    logic [15:0]     mem [MAX_REQUESTS];
    logic [15:0]     rd_data_reg;
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [15:0]     wr_data;

    // datapath helpers
    logic            s_fire, out_free, is_sort;
    logic [15:0]     head, rd_clamp;
    logic [CW-1:0]   i_m1, j_m2, first_m1;
    logic            emit_fire, emit_last;
    logic [15:0]     emit_trk, emit_dist;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_FCFS;
            head_start_reg <= 16'd0;
            max_cyl_reg    <= MAX_CYL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:    mode_reg       <= cfg_wdata[1:0];
                REG_HEAD:    head_start_reg <= cfg_wdata;
                REG_MAX_CYL: max_cyl_reg    <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // request memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // clamping and small arithmetic
    assign head     = (head_start_reg > max_cyl_reg) ? max_cyl_reg : head_start_reg;
    assign rd_clamp = (rd_data_reg > max_cyl_reg) ? max_cyl_reg : rd_data_reg;
    assign i_m1     = i_reg - CW'(1);
    assign j_m2     = j_reg - CW'(2);
    assign first_m1 = first_reg - CW'(1);
    assign s_ready  = (state_reg == S_LOAD);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        is_sort = mode_reg inside {MODE_SCAN, MODE_CSCAN};
    end

    // result selection for the emit states
    always_comb begin
        emit_trk = rd_clamp;
        case (state_reg)
            S_EMIT_TOP:  emit_trk = max_cyl_reg;
            S_EMIT_ZERO: emit_trk = 16'd0;
            default:     emit_trk = rd_clamp;
        endcase
        emit_dist = (emit_trk >= pos_reg) ? (emit_trk - pos_reg) : (pos_reg - emit_trk);
        emit_fire = out_free && ((state_reg == S_EMIT_WR) || (state_reg == S_EMIT_TOP)
                                 || (state_reg == S_EMIT_ZERO));
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        seg_next   = seg_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        x_next     = x_reg;
        pos_next   = pos_reg;
        tot_next   = tot_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = s_data.request_track;
        rd_en      = 1'b0;
        rd_addr    = i_reg[AW-1:0];
        emit_last  = 1'b0;

        case (state_reg)
            // collect requests
            S_LOAD: begin
                if (s_fire) begin
                    if (count_reg < CW'(MAX_REQUESTS)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (s_data.last_request) begin
                        state_next = S_START;
                    end
                end
            end

            // batch closed, pick the path
            S_START: begin
                pos_next   = head;
                tot_next   = 21'd0;
                first_next = '0;
                i_next     = CW'(1);
                if (!is_sort) begin
                    seg_next   = SEG_UP;
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end else if (count_reg <= CW'(1)) begin
                    state_next = S_FIND_RD;
                end else begin
                    state_next = S_SORT_RD;
                end
            end

            // insertion sort: fetch the element to insert
            S_SORT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = i_reg[AW-1:0];
                state_next = S_SORT_X;
            end

            S_SORT_X: begin
                x_next     = rd_clamp;
                j_next     = i_reg;
                rd_en      = 1'b1;
                rd_addr    = i_m1[AW-1:0];
                state_next = S_SORT_CMP;
            end

            // shift larger neighbors up, or drop the element in place
            S_SORT_CMP: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                if (rd_clamp > x_reg) begin
                    wr_data = rd_clamp;
                    j_next  = j_reg - CW'(1);
                    if (j_reg == CW'(1)) begin
                        state_next = S_SORT_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = j_m2[AW-1:0];
                    end
                end else begin
                    wr_data = x_reg;
                    if ((i_reg + CW'(1)) < count_reg) begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_SORT_RD;
                    end else begin
                        state_next = S_FIND_RD;
                    end
                end
            end

            S_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = x_reg;
                if ((i_reg + CW'(1)) < count_reg) begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SORT_RD;
                end else begin
                    state_next = S_FIND_RD;
                end
            end

            // find the first sorted request at or above the head
            S_FIND_RD: begin
                seg_next = SEG_UP;
                idx_next = first_reg;
                if (first_reg == count_reg) begin
                    state_next = S_EMIT_TOP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = first_reg[AW-1:0];
                    state_next = S_FIND_CMP;
                end
            end

            S_FIND_CMP: begin
                if (rd_clamp < head) begin
                    first_next = first_reg + CW'(1);
                    state_next = S_FIND_RD;
                end else begin
                    seg_next   = SEG_UP;
                    idx_next   = first_reg;
                    state_next = S_EMIT_RD;
                end
            end

            // emission from the store
            S_EMIT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg[AW-1:0];
                state_next = S_EMIT_WR;
            end

            S_EMIT_WR: begin
                case (seg_reg)
                    SEG_UP: begin
                        if ((idx_reg + CW'(1)) < count_reg) begin
                            if (emit_fire) begin
                                idx_next   = idx_reg + CW'(1);
                                state_next = S_EMIT_RD;
                            end
                        end else if (!is_sort) begin
                            emit_last = 1'b1;
                        end else if (emit_fire) begin
                            state_next = S_EMIT_TOP;
                        end
                    end
                    SEG_DN: begin
                        if (idx_reg == '0) begin
                            emit_last = 1'b1;
                        end else if (emit_fire) begin
                            idx_next   = idx_reg - CW'(1);
                            state_next = S_EMIT_RD;
                        end
                    end
                    SEG_CU: begin
                        if ((idx_reg + CW'(1)) == first_reg) begin
                            emit_last = 1'b1;
                        end else if (emit_fire) begin
                            idx_next   = idx_reg + CW'(1);
                            state_next = S_EMIT_RD;
                        end
                    end
                    default: emit_last = 1'b1;
                endcase
            end

            // turnaround at the top cylinder
            S_EMIT_TOP: begin
                if (mode_reg == MODE_CSCAN) begin
                    if (emit_fire) begin
                        state_next = S_EMIT_ZERO;
                    end
                end else if (first_reg == '0) begin
                    emit_last = 1'b1;
                end else if (emit_fire) begin
                    seg_next   = SEG_DN;
                    idx_next   = first_m1;
                    state_next = S_EMIT_RD;
                end
            end

            // jump back to cylinder zero
            S_EMIT_ZERO: begin
                if (first_reg == '0) begin
                    emit_last = 1'b1;
                end else if (emit_fire) begin
                    seg_next   = SEG_CU;
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
            end

            default: state_next = S_LOAD;
        endcase

        // bookkeeping for an emitted result
        if (emit_fire) begin
            pos_next = emit_trk;
            tot_next = tot_reg + 21'(emit_dist);
            if (emit_last) begin
                count_next = '0;
                state_next = S_LOAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        seg_reg   <= seg_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        idx_reg   <= idx_next;
        first_reg <= first_next;
        x_reg     <= x_next;
        pos_reg   <= pos_next;
        tot_reg   <= tot_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_data_reg.served_track   <= emit_trk;
            m_data_reg.move_distance  <= emit_dist;
            m_data_reg.total_movement <= tot_next;
            m_data_reg.request_count  <= 6'(count_reg);
            m_data_reg.last_served    <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // the batch never holds more than the capacity
    `ASSERT_CLKD(a_count_cap, count_reg <= CW'(MAX_REQUESTS))
    // the final result of a batch reopens loading with an empty store
    `ASSERT_CLKD(a_last_reopens, (emit_fire && emit_last) |=> (s_ready && count_reg == '0))
    // sort writes stay inside the stored batch
    `ASSERT_CLKD(a_sort_wr_range, (wr_en && state_reg != S_LOAD) |-> (CW'(wr_addr) < count_reg))
    // the insertion index stays between one and the element being inserted
    `ASSERT_CLKD(a_sort_j_range, (state_reg == S_SORT_CMP) |-> (j_reg != '0 && j_reg <= i_reg))

endmodule

`default_nettype wire

### tb/disk_request_scheduler_test.sv
`default_nettype none

module disk_request_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import drs_pkg::*;

    localparam int unsigned CAPACITY     = MAX_REQUESTS_DEF;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_OFF_LONG = 400;
    localparam int unsigned MAX_REPORTS  = 10;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    req_t        s_data;
    logic        m_valid;
    logic        m_ready;
    res_t        m_data;

    // register copies used for prediction
    logic [1:0]  cfg_mode;
    logic [15:0] cfg_head;
    logic [15:0] cfg_top;

    // requests kept in the current batch, and service results still owed
    logic [15:0] batch_tracks[$];
    res_t        expected_services[$];

    // scratch state while building one service order
    int unsigned svc_pos;
    int unsigned svc_sum;
    int unsigned svc_index;
    int unsigned svc_total;
    int unsigned svc_kept;

    int unsigned mismatch_count;
    int unsigned burst_left;
    int unsigned hold_off_cycles;

    disk_request_scheduler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // append one visited cylinder to the expected service order
    function automatic void add_service(input int unsigned track);
        res_t        r;
        int unsigned moved;
        moved = (track >= svc_pos) ? track - svc_pos : svc_pos - track;
        svc_sum = svc_sum + moved;
        svc_pos = track;
        r.served_track   = 16'(track);
        r.move_distance  = 16'(moved);
        r.total_movement = 21'(svc_sum);
        r.request_count  = 6'(svc_kept);
        r.last_served    = (svc_index == svc_total - 1);
        expected_services.push_back(r);
        svc_index++;
    endfunction

    // compute the service order for the batch just closed
    function automatic void predict_service_order();
        int unsigned sorted[$];
        int unsigned head;
        int unsigned first;
        int unsigned n;
        n = batch_tracks.size();
        head = (cfg_head > cfg_top) ? cfg_top : cfg_head;
        foreach (batch_tracks[i])
            sorted.push_back((batch_tracks[i] > cfg_top) ? cfg_top : batch_tracks[i]);
        svc_pos = head;
        svc_sum = 0;
        svc_index = 0;
        svc_kept = n;
        if (cfg_mode == MODE_SCAN || cfg_mode == MODE_CSCAN) begin
            sorted.sort();
            first = 0;
            while (first < n && sorted[first] < head) first++;
            svc_total = (cfg_mode == MODE_SCAN) ? n + 1 : n + 2;
            for (int unsigned i = first; i < n; i++) add_service(sorted[i]);
            add_service(cfg_top);
            if (cfg_mode == MODE_SCAN) begin
                for (int unsigned i = first; i > 0; i--) add_service(sorted[i - 1]);
            end else begin
                add_service(0);
                for (int unsigned i = 0; i < first; i++) add_service(sorted[i]);
            end
        end else begin
            // first come first served, unused mode code included
            svc_total = n;
            for (int unsigned i = 0; i < n; i++) add_service(sorted[i]);
        end
        batch_tracks.delete();
    endfunction

    // offer one request beat, with burst and gap shaping
    task automatic send_request(input logic [15:0] track, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_data.request_track <= track;
        s_data.last_request  <= last;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        // capacity full drops the request, the marker still closes the batch
        if (batch_tracks.size() < CAPACITY) batch_tracks.push_back(track);
        if (last) predict_service_order();
    endtask

    // let the block finish every owed result and settle
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (expected_services.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all three registers on consecutive cycles
    task automatic write_registers(input logic [1:0] mode, input logic [15:0] head,
                                   input logic [15:0] top);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_wdata <= {14'd0, mode};
        @(posedge aclk);
        cfg_index <= REG_HEAD;
        cfg_wdata <= head;
        @(posedge aclk);
        cfg_index <= REG_MAX_CYL;
        cfg_wdata <= top;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_mode = mode;
        cfg_head = head;
        cfg_top  = top;
    endtask

    // cylinder biased toward the ends and the clamp
    function automatic logic [15:0] pick_track(input logic [15:0] top);
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return top;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    task automatic pick_config();
        logic [1:0]  mode;
        logic [15:0] head;
        logic [15:0] top;
        mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 4))
            0: top = 16'd1;
            1: top = 16'hFFFF;
            2: top = MAX_CYL_RESET;
            default: top = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 4))
            0: head = 16'd0;
            1: head = top;
            2: head = 16'hFFFF;
            default: head = 16'($urandom_range(0, top));
        endcase
        write_registers(mode, head, top);
    endtask

    task automatic send_batch(input int unsigned size);
        for (int unsigned i = 0; i < size; i++)
            send_request(pick_track(cfg_top), i == size - 1);
    endtask

    // directed: arrival order, clamp of a request, single request batch
    task automatic test_fcfs_directed();
        write_registers(MODE_FCFS, 16'd50, MAX_CYL_RESET);
        send_request(16'd0, 1'b0);
        send_request(16'd199, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd100, 1'b1);
        send_request(16'd7, 1'b1);
        wait_until_drained();
    endtask

    // directed: scan with a request already at the top and one at the head
    task automatic test_scan_directed();
        write_registers(MODE_SCAN, 16'd100, MAX_CYL_RESET);
        send_request(16'd150, 1'b0);
        send_request(16'd199, 1'b0);
        send_request(16'd20, 1'b0);
        send_request(16'd100, 1'b0);
        send_request(16'hFFFF, 1'b1);
        wait_until_drained();
    endtask

    // directed: circular scan with the head above the top, then at zero
    task automatic test_cscan_directed();
        write_registers(MODE_CSCAN, 16'hFFFF, MAX_CYL_RESET);
        send_request(16'd5, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd180, 1'b0);
        send_request(16'd199, 1'b1);
        wait_until_drained();
        write_registers(MODE_CSCAN, 16'd0, 16'hFFFF);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd3, 1'b1);
        wait_until_drained();
    endtask

    // directed: unused mode code and the smallest top cylinder
    task automatic test_mode_and_top_extremes();
        write_registers(MODE_UNUSED, 16'd9, 16'd300);
        send_request(16'd400, 1'b0);
        send_request(16'd2, 1'b1);
        wait_until_drained();
        write_registers(MODE_SCAN, 16'd1, 16'd1);
        send_request(16'd0, 1'b0);
        send_request(16'd1, 1'b0);
        send_request(16'hFFFF, 1'b1);
        wait_until_drained();
    endtask

    // random batches under random settings
    task automatic test_random_batches();
        int unsigned sent;
        int unsigned size;
        sent = 0;
        while (sent < 150) begin
            pick_config();
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, CAPACITY)
                                               : $urandom_range(1, 12);
            send_batch(size);
            sent = sent + size;
            wait_until_drained();
        end
    endtask

    // batches longer than the store: extra requests are dropped
    task automatic test_capacity_overflow();
        write_registers(MODE_SCAN, 16'($urandom_range(0, 1000)), 16'd1000);
        send_batch(CAPACITY + 3);
        wait_until_drained();
        write_registers(MODE_FCFS, 16'd0, 16'hFFFF);
        send_batch(CAPACITY + 1);
        wait_until_drained();
    endtask

    // receiver holds off while several batches queue up behind it
    task automatic test_backpressure();
        write_registers(MODE_CSCAN, 16'd500, 16'd2000);
        hold_off_cycles = HOLD_OFF_LONG;
        for (int unsigned b = 0; b < 3; b++) send_batch($urandom_range(4, 10));
        wait_until_drained();
    endtask

    // receiver: alternating ready and stall runs, long hold-off on request
    initial begin
        bit          ready_phase;
        int unsigned run_left;
        ready_phase = 1'b0;
        run_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end
            if (run_left == 0) begin
                ready_phase = !ready_phase;
                if (ready_phase)
                    run_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 10);
                else
                    run_left = $urandom_range(1, 6);
            end
            run_left--;
            m_ready <= ready_phase;
        end
    end

    // compare every result beat with the oldest expected one
    always @(posedge aclk) begin
        res_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_services.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected beat: trk %0d mv %0d tot %0d cnt %0d last %0b",
                             m_data.served_track, m_data.move_distance,
                             m_data.total_movement, m_data.request_count, m_data.last_served);
            end else begin
                exp_res = expected_services.pop_front();
                if (m_data.served_track !== exp_res.served_track ||
                    m_data.move_distance !== exp_res.move_distance ||
                    m_data.total_movement !== exp_res.total_movement ||
                    m_data.request_count !== exp_res.request_count ||
                    m_data.last_served !== exp_res.last_served) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                                 exp_res.served_track, exp_res.move_distance,
                                 exp_res.total_movement, exp_res.request_count,
                                 exp_res.last_served, m_data.served_track,
                                 m_data.move_distance, m_data.total_movement,
                                 m_data.request_count, m_data.last_served);
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        mismatch_count  = 0;
        burst_left      = 0;
        hold_off_cycles = 0;
        cfg_mode = MODE_FCFS;
        cfg_head = 16'd0;
        cfg_top  = MAX_CYL_RESET;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_MODE;
        cfg_wdata <= 16'd0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        test_fcfs_directed();
        test_scan_directed();
        test_cscan_directed();
        test_mode_and_top_extremes();
        test_random_batches();
        test_capacity_overflow();
        test_backpressure();

        wait_until_drained();
        if (mismatch_count == 0 && expected_services.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/drs_pkg.sv
src/disk_request_scheduler.sv
tb/disk_request_scheduler_test.sv
